>>> hw/rtl/gcvs_pkg.sv
// Shared types, widths and constants of the garbage-collection victim selector.
package gcvs_pkg;

    // Field and register widths.
    localparam int VALID_W    = 13;
    localparam int ERASE_W    = 20;
    localparam int WEIGHT_W   = 24;
    localparam int VICTIM_W   = 12;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    // Fixed-point layout: cost is Q34.16, the wear weight is Q8.16.
    localparam int FRAC_BITS = 16;
    localparam int COST_W    = 50;
    localparam int PROD_W    = VALID_W + ERASE_W;
    localparam int DIVIDEND_W = PROD_W + FRAC_BITS;
    localparam int PENALTY_W = WEIGHT_W + ERASE_W;
    localparam int DIV_CNT_W = $clog2(DIVIDEND_W);

    // Scan limits.
    localparam int MAX_CANDIDATES  = 4096;
    localparam int PAGES_PER_BLOCK = 4096;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEAR_WEIGHT = 1'd1;
    localparam logic [ERASE_W-1:0]   ERASE_LIMIT_RESET = 20'd3000;
    localparam logic [WEIGHT_W-1:0]  WEAR_WEIGHT_RESET = 24'd3277;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUM,
        ST_UPDATE,
        ST_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mul;
        logic div_start;
        logic sum;
        logic update;
        logic advance;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finite;
        logic is_last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/gcvs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module gcvs_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [gcvs_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [gcvs_pkg::ERASE_W-1:0]       divisor,
    output logic [gcvs_pkg::DIVIDEND_W-1:0]    quotient,
    output logic                               done
);
    import gcvs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [ERASE_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  count_reg, count_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ERASE_W:0]      rem_shift;
    logic [ERASE_W:0]      diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff       = rem_shift - {1'b0, divisor};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[ERASE_W])
            begin
                rem_next = diff[ERASE_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[ERASE_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> hw/rtl/gcvs_datapath.sv
// Datapath: configuration, cost arithmetic, running minimum and result register.
module gcvs_datapath #(
    parameter int MAX_CANDIDATES = gcvs_pkg::MAX_CANDIDATES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [gcvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcvs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [gcvs_pkg::VALID_W-1:0]      valid_pages,
    input  logic [gcvs_pkg::ERASE_W-1:0]      pe_count,
    input  logic                              last,
    input  gcvs_pkg::ctrl_cmd_t               cmd,
    output gcvs_pkg::dp_status_t              status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [gcvs_pkg::VICTIM_W-1:0]     victim_index
);
    import gcvs_pkg::*;

    localparam int POS_W = $clog2(MAX_CANDIDATES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_CANDIDATES - 1);
    localparam int SAT_W = 17;
    localparam logic [SAT_W-1:0] PAGES_SAT = SAT_W'(PAGES_PER_BLOCK);

    // Configuration registers.
    logic [ERASE_W-1:0]  erase_limit_reg;
    logic [WEIGHT_W-1:0] wear_weight_reg;

    // Captured request.
    logic [VALID_W-1:0] valid_sat_reg;
    logic [ERASE_W-1:0] pe_reg;
    logic [ERASE_W-1:0] lim_reg;
    logic               last_reg;

    // Arithmetic stages.
    logic [PROD_W-1:0]     prod_reg;
    logic [PENALTY_W-1:0]  penalty_reg;
    logic [ERASE_W-1:0]    divisor_reg;
    logic                  finite_reg;
    logic [COST_W-1:0]     cost_reg;
    logic [DIVIDEND_W-1:0] quotient;
    logic                  div_done;

    // Scan state.
    logic [POS_W-1:0]  position_reg;
    logic [COST_W-1:0] best_cost_reg;
    logic [POS_W-1:0]  best_position_reg;
    logic              have_best_reg;

    // Result register.
    logic                out_valid_reg;
    logic                found_reg;
    logic [VICTIM_W-1:0] victim_reg;

    logic               out_free;
    logic [VALID_W-1:0] valid_sat;
    logic               better;

    assign out_free = !out_valid_reg || out_ready;

    // Saturate the page count to the block size.
    assign valid_sat = ({4'd0, valid_pages} > PAGES_SAT) ? VALID_W'(PAGES_PER_BLOCK)
                                                         : valid_pages;

    assign better = finite_reg && (!have_best_reg || (cost_reg < best_cost_reg));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_limit_reg <= ERASE_LIMIT_RESET;
            wear_weight_reg <= WEAR_WEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ERASE_LIMIT: erase_limit_reg <= cfg_data[ERASE_W-1:0];
                REG_WEAR_WEIGHT: wear_weight_reg <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture, the multiply stage and the cost sum.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            valid_sat_reg <= valid_sat;
            pe_reg        <= pe_count;
            last_reg      <= last;
            lim_reg       <= (erase_limit_reg != '0) ? erase_limit_reg : ERASE_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg    <= PROD_W'(valid_sat_reg) * PROD_W'(lim_reg);
            penalty_reg <= PENALTY_W'(wear_weight_reg) * PENALTY_W'(pe_reg);
            divisor_reg <= lim_reg - pe_reg;
        end
        if (cmd.sum)
        begin
            cost_reg <= COST_W'(quotient) + COST_W'(penalty_reg);
        end
    end

    // A worn block has infinite cost and is skipped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finite_reg <= 1'b0;
        end
        else if (cmd.mul)
        begin
            finite_reg <= pe_reg < lim_reg;
        end
    end

    // Iterative divider for the page term.
    gcvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({prod_reg, FRAC_BITS'(0)}),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Running minimum and list position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg      <= '0;
            best_cost_reg     <= '1;
            best_position_reg <= '0;
            have_best_reg     <= 1'b0;
        end
        else if (cmd.emit)
        begin
            position_reg      <= '0;
            best_cost_reg     <= '1;
            best_position_reg <= '0;
            have_best_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.update && better)
            begin
                best_cost_reg     <= cost_reg;
                best_position_reg <= position_reg;
                have_best_reg     <= 1'b1;
            end
            if (cmd.advance)
            begin
                position_reg <= (position_reg == POS_LAST) ? '0 : position_reg + 1'b1;
            end
        end
    end

    // Result register, free again once the result has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            found_reg  <= have_best_reg;
            victim_reg <= have_best_reg ? VICTIM_W'(best_position_reg) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign victim_index = victim_reg;

    assign status.finite   = finite_reg;
    assign status.is_last  = last_reg;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

endmodule

>>> hw/rtl/gcvs_ctrl.sv
// Controller state machine that sequences one candidate through the datapath.
module gcvs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gcvs_pkg::dp_status_t  status,
    output gcvs_pkg::ctrl_cmd_t   cmd
);
    import gcvs_pkg::*;

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                if (status.finite)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.is_last)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/flash_gc_victim_select_core.sv
// Top level of the wear-aware garbage-collection victim selector.
// Candidates arrive one request at a time and the block keeps the one with the lowest
// cost valid_pages*E/(E-pe_count) + wear_weight*pe_count in Q34.16, where E is
// erase_limit or 1 when it is zero; blocks with pe_count >= E are never chosen and
// the earliest of equal costs wins. A request marked last produces one result (found,
// victim_index) and starts a new list. A candidate with finite cost goes from acceptance
// through ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_SUM and ST_UPDATE before the next acceptance;
// the radix-2 divider produces one of the 49 quotient bits per cycle. A worn candidate skips
// ST_DIV_WAIT and ST_SUM. A last request waits in ST_RESULT until the previous result is taken.
module flash_gc_victim_select_core #(
    parameter int MAX_CANDIDATES = gcvs_pkg::MAX_CANDIDATES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [gcvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcvs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [gcvs_pkg::VALID_W-1:0]      valid_pages,
    input  logic [gcvs_pkg::ERASE_W-1:0]      pe_count,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [gcvs_pkg::VICTIM_W-1:0]     victim_index
);
    import gcvs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer.
    gcvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and scan state.
    gcvs_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .valid_pages  (valid_pages),
        .pe_count     (pe_count),
        .last         (last),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .victim_index (victim_index)
    );

    // A request is worked on alone: no new request right after one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while the previous one is still in work");

    // The divider only runs for a block with finite cost.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> status.finite)
        else $error("divider started for a worn block");

    // A result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted while the result register is occupied");

    // A report without a victim gives index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> victim_index == '0)
        else $error("nonzero victim index without a victim");

endmodule

>>> tb/tb_flash_gc_victim_select_core.sv
// Self-checking testbench of the garbage-collection victim selector with a scoreboard class.
`timescale 1ns / 100ps

module tb_flash_gc_victim_select_core;
    import gcvs_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 240;
    localparam logic [63:0] COST_ALL_ONES = (64'd1 << COST_W) - 64'd1;

    // One victim report as the block should give it.
    typedef struct packed {
        logic                found;
        logic [VICTIM_W-1:0] victim;
    } victim_result_t;

    // Tracks the running minimum-cost candidate and holds the reports still owed.
    class victim_scoreboard;
        logic [ERASE_W-1:0]  erase_limit;
        logic [WEIGHT_W-1:0] wear_weight;
        logic [31:0]         scan_pos;
        logic [COST_W-1:0]   best_cost;
        logic [31:0]         best_pos;
        bit                  have_best;
        victim_result_t      owed_q[$];
        int                  errors;

        function new();
            erase_limit = ERASE_LIMIT_RESET;
            wear_weight = WEAR_WEIGHT_RESET;
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            scan_pos  = '0;
            best_cost = COST_ALL_ONES[COST_W-1:0];
            best_pos  = '0;
            have_best = 1'b0;
        endfunction

        function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ERASE_LIMIT)
                erase_limit = data[ERASE_W-1:0];
            else if (idx == REG_WEAR_WEIGHT)
                wear_weight = data[WEIGHT_W-1:0];
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        // Scores one accepted candidate request; a last request closes the list.
        function void note_candidate(input logic [VALID_W-1:0] pages,
                                     input logic [ERASE_W-1:0] wear,
                                     input logic is_last);
            logic [63:0]    lim;
            logic [63:0]    pg;
            logic [63:0]    wear64;
            logic [63:0]    quotient;
            logic [63:0]    cost;
            victim_result_t res;
            lim    = (erase_limit == '0) ? 64'd1 : 64'(erase_limit);
            pg     = (pages > PAGES_PER_BLOCK) ? 64'(PAGES_PER_BLOCK) : 64'(pages);
            wear64 = 64'(wear);
            // Worn blocks have infinite cost and only move the position on.
            if (wear64 < lim) begin
                quotient = ((pg * lim) << FRAC_BITS) / (lim - wear64);
                cost     = quotient + 64'(wear_weight) * wear64;
                if (cost > COST_ALL_ONES)
                    cost = COST_ALL_ONES;
                if (!have_best || cost[COST_W-1:0] < best_cost) begin
                    best_cost = cost[COST_W-1:0];
                    best_pos  = scan_pos;
                    have_best = 1'b1;
                end
            end
            if (is_last) begin
                res.found  = have_best;
                res.victim = have_best ? best_pos[VICTIM_W-1:0] : '0;
                owed_q.push_back(res);
                clear_scan();
            end
            else begin
                scan_pos = scan_pos + 1;
                if (scan_pos >= MAX_CANDIDATES)
                    scan_pos = '0;
            end
        endfunction

        // Compares one accepted report with the oldest one owed.
        function void check_result(input logic got_found, input logic [VICTIM_W-1:0] got_victim);
            victim_result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected report found=%0d victim_index=%0d",
                         $time, got_found, got_victim);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got_found !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got_found);
                errors++;
            end
            if (got_victim !== want.victim) begin
                $display("%0t: victim_index expected %0d actual %0d",
                         $time, want.victim, got_victim);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [VALID_W-1:0]    valid_pages;
    logic [ERASE_W-1:0]    pe_count;
    logic                  last;
    logic                  out_valid;
    logic                  out_ready;
    logic                  found;
    logic [VICTIM_W-1:0]   victim_index;

    victim_scoreboard sb;
    int               stall_cycles;
    bit               send_idling;
    bit               ready_idling;
    bit               timed_out;

    flash_gc_victim_select_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .valid_pages  (valid_pages),
        .pe_count     (pe_count),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .victim_index (victim_index)
    );

    always #CLK_HALF clk = ~clk;

    // Result side stalls at random unless the quiet stretch is running.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !(ready_idling && $urandom_range(0, 99) < 20);
    end

    // Observes both handshakes at the edge and counts cycles without progress.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (out_valid && out_ready)
                sb.check_result(found, victim_index);
            if (in_valid && in_ready)
                sb.note_candidate(valid_pages, pe_count, last);
        end
    end

    function automatic logic [VALID_W-1:0] pick_pages();
        case ($urandom_range(0, 13))
            0: return '0;
            1: return VALID_W'(PAGES_PER_BLOCK);
            2: return VALID_W'(PAGES_PER_BLOCK + 1);
            3: return '1;
            4, 5: return VALID_W'($urandom);
            default: return VALID_W'($urandom_range(0, PAGES_PER_BLOCK));
        endcase
    endfunction

    // Mostly finite erase counts, some near the limit and some anywhere.
    function automatic logic [ERASE_W-1:0] pick_wear(input logic [31:0] lim);
        case ($urandom_range(0, 9))
            0: return ERASE_W'($urandom);
            1: return ERASE_W'(lim - 1 + $urandom_range(0, 2));
            default: return ERASE_W'($urandom_range(0, lim - 1));
        endcase
    endfunction

    // Sends one candidate request, with an occasional gap before it.
    task automatic send_candidate(input logic [VALID_W-1:0] pages,
                                  input logic [ERASE_W-1:0] wear,
                                  input logic is_last);
        if (send_idling && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        valid_pages <= pages;
        pe_count    <= wear;
        last        <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic write_config(input logic [CFG_DATA_W-1:0] limit_data,
                                input logic [CFG_DATA_W-1:0] weight_data);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_ERASE_LIMIT;
        cfg_data     <= limit_data;
        @(posedge clk);
        sb.write_register(REG_ERASE_LIMIT, limit_data);
        cfg_index <= REG_WEAR_WEIGHT;
        cfg_data  <= weight_data;
        @(posedge clk);
        sb.write_register(REG_WEAR_WEIGHT, weight_data);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Lets every owed report arrive, then gives the block time to settle.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random candidate lists, with repeated candidates to provoke ties.
    task automatic run_random_phase(input int items);
        int                 sent;
        int                 len;
        logic [31:0]        lim;
        logic [VALID_W-1:0] pages;
        logic [ERASE_W-1:0] wear;
        sent  = 0;
        pages = '0;
        wear  = '0;
        lim   = (sb.erase_limit == '0) ? 32'd1 : 32'(sb.erase_limit);
        while (sent < items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (i == 0 || $urandom_range(0, 99) >= 15) begin
                    pages = pick_pages();
                    wear  = pick_wear(lim);
                end
                send_candidate(pages, wear, i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic run_stimulus();
        // Single-candidate lists: a fresh block, then a worn one.
        send_candidate('0, '0, 1'b1);
        send_candidate(13'd4096, 20'd3000, 1'b1);
        // Saturated page counts tie and the first wins; a later cheap block takes over.
        send_candidate(13'd4096, '0, 1'b0);
        send_candidate('1, '0, 1'b0);
        send_candidate('0, 20'd2999, 1'b0);
        send_candidate(13'd5, 20'd100, 1'b1);
        // All candidates worn out.
        send_candidate('0, '1, 1'b0);
        send_candidate('1, 20'd3000, 1'b0);
        send_candidate(13'd1, 20'd5000, 1'b1);
        // Equal costs keep the earliest.
        send_candidate(13'd100, 20'd10, 1'b0);
        send_candidate(13'd100, 20'd10, 1'b0);
        send_candidate(13'd100, 20'd10, 1'b1);
        finish_phase();

        // A zero erase limit acts as one; upper data bits are not part of the register.
        write_config(24'hF00000, CFG_DATA_W'(WEAR_WEIGHT_RESET));
        send_candidate(13'd4096, '0, 1'b0);
        send_candidate('0, 20'd1, 1'b0);
        send_candidate('0, '0, 1'b1);
        finish_phase();

        // Largest limit and weight.
        write_config({4'h0, 20'hFFFFF}, 24'hFFFFFF);
        send_candidate(13'd4096, 20'hFFFFE, 1'b0);
        send_candidate('1, '0, 1'b0);
        send_candidate('0, '1, 1'b1);
        finish_phase();

        // No wear penalty at all.
        write_config(24'd1, '0);
        send_candidate('1, '0, 1'b0);
        send_candidate('0, '0, 1'b1);
        finish_phase();

        // Random lists under several settings; the fourth phase runs without any idling.
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: write_config(24'hF00000, CFG_DATA_W'($urandom));
                1: write_config(24'd1, '0);
                2: write_config({4'h0, 20'hFFFFF}, 24'hFFFFFF);
                3: write_config(CFG_DATA_W'(ERASE_LIMIT_RESET), CFG_DATA_W'(WEAR_WEIGHT_RESET));
                default: write_config({4'($urandom), ($urandom_range(0, 1) != 0) ?
                                       20'($urandom_range(2, 64)) : 20'($urandom)},
                                      CFG_DATA_W'($urandom));
            endcase
            send_idling  = (p != 3);
            ready_idling = (p != 3);
            run_random_phase(PHASE_ITEMS);
            finish_phase();
        end
        send_idling  = 1'b1;
        ready_idling = 1'b1;
    endtask

    task automatic watch_for_stall();
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        timed_out = 1'b1;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        valid_pages  = '0;
        pe_count     = '0;
        last         = 1'b0;
        send_idling  = 1'b1;
        ready_idling = 1'b1;
        timed_out    = 1'b0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            run_stimulus();
            watch_for_stall();
        join_any
        if (timed_out)
            $display("tb: failure");
        else if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gcvs_pkg.sv
hw/rtl/gcvs_div.sv
hw/rtl/gcvs_datapath.sv
hw/rtl/gcvs_ctrl.sv
hw/rtl/flash_gc_victim_select_core.sv
tb/tb_flash_gc_victim_select_core.sv
